// File: src/dgpe_pkg.sv
// ----------------------------------------------------------------------------
// dgpe_pkg
// Shared widths, payload structs and result batch type for the gap-coding
// posting list encoder.
// ----------------------------------------------------------------------------
package dgpe_pkg;

    // Code word and identifier widths (fixed by the transaction payloads)
    localparam int WORD_BITS   = 32;
    localparam int ID_BITS     = 31;

    // Longest code: top ones, a zero and top low bits, top at most ID_BITS-1
    localparam int CODE_BITS   = 2 * ID_BITS - 1;
    // Full words that one identifier can complete, on top of a partial word
    localparam int MAX_WORDS   = (WORD_BITS - 1 + CODE_BITS) / WORD_BITS;
    // Full words plus one flush or error transaction
    localparam int MAX_RESULTS = MAX_WORDS + 1;
    // Working window: partial word followed by the aligned code
    localparam int STREAM_BITS = (MAX_WORDS + 1) * WORD_BITS;

    localparam int FILL_BITS   = $clog2(WORD_BITS);
    localparam int TOP_BITS    = $clog2(ID_BITS);
    localparam int LEN_BITS    = $clog2(STREAM_BITS + 1);
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    // Result queue, a power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH  = 16;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int LVL_BITS    = PTR_BITS + 1;

    typedef struct packed {
        logic [ID_BITS-1:0] doc_id;
        logic               end_of_list;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic                 is_last;
        logic [FILL_BITS-1:0] next_free_bit;
        logic                 order_error;
    } out_item_t;

    // Results raised by one identifier, slot 0 first
    typedef struct packed {
        logic [CNT_BITS-1:0]               count;
        out_item_t [MAX_RESULTS-1:0]       res;
    } res_batch_t;

endpackage

// File: src/delta_gamma_posting_encoder_top.sv
// ----------------------------------------------------------------------------
// delta_gamma_posting_encoder_top
// Gamma codes the gaps of a rising identifier list and packs the codes, most
// significant bit first, into 32-bit words.
// ----------------------------------------------------------------------------
//  Channel  Ports                      Direction  Transaction
//  s_       s_valid s_ready s_item     in         doc_id, end_of_list
//  m_       m_valid m_ready m_item     out        packed_word, is_last,
//                                                 next_free_bit, order_error
//
// One identifier per cycle while s_ready is high: input register, then
// combinational gap, encode and shift logic, then a 16-entry result queue.
// Results show on m_ once written to the queue. Each identifier yields up
// to three transactions; s_ready drops while the queue could not hold the
// results of the identifier in flight plus one more. Synchronous reset
// clears the coder state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module delta_gamma_posting_encoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dgpe_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output dgpe_pkg::out_item_t m_item
);
    import dgpe_pkg::*;

    logic                in_valid_reg;
    in_item_t            in_item_reg;
    res_batch_t          batch;
    logic [LVL_BITS-1:0] level;
    logic [LVL_BITS:0]   committed;

    // Accept only with room for the in-flight identifier's results plus one more
    always_comb begin
        committed = {1'b0, level}
                  + (in_valid_reg ? (LVL_BITS + 1)'(MAX_RESULTS) : '0);
        s_ready   = (committed <= (LVL_BITS + 1)'(FIFO_DEPTH - MAX_RESULTS));
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    dgpe_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_item  (in_item_reg),
        .batch    (batch)
    );

    dgpe_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_batch (batch),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_item  (m_item),
        .level    (level)
    );

endmodule

// File: src/dgpe_packer.sv
// ----------------------------------------------------------------------------
// dgpe_packer
// Gap, gamma code and word packing for one identifier per cycle; holds the
// partial word, fill position and previous identifier.
// ----------------------------------------------------------------------------
module dgpe_packer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  dgpe_pkg::in_item_t    in_item,
    output dgpe_pkg::res_batch_t  batch
);
    import dgpe_pkg::*;

    logic [WORD_BITS-1:0]   partial_reg, partial_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [ID_BITS-1:0]     prev_reg, prev_next;

    logic                   err;
    logic [ID_BITS-1:0]     gap;
    logic [TOP_BITS-1:0]    top;
    logic [ID_BITS-1:0]     gap_norm;
    logic [CODE_BITS-1:0]   low_field;
    logic [CODE_BITS-1:0]   code_lj;
    logic [LEN_BITS-1:0]    code_len;
    logic [FILL_BITS-1:0]   used;
    logic [STREAM_BITS-1:0] stream;
    logic [LEN_BITS-1:0]    total;
    logic [LEN_BITS-1:0]    full_bits;
    logic [CNT_BITS-1:0]    nfull;
    logic [WORD_BITS-1:0]   rem_word;
    logic [LEN_BITS-1:0]    rem_bits;
    logic [FILL_BITS-1:0]   new_fill;
    out_item_t              tail;
    logic                   tail_en;

    // Gap to the previous identifier and its top set bit
    always_comb begin
        err = (in_item.doc_id <= prev_reg);
        gap = in_item.doc_id - prev_reg;
        top = '0;
        for (int p = 0; p < ID_BITS; p++) begin
            if (gap[p]) begin
                top = TOP_BITS'(p);
            end
        end
    end

    // Build the code left-justified: top ones, a zero, then the low bits
    always_comb begin
        gap_norm  = gap << (TOP_BITS'(ID_BITS - 1) - top);
        low_field = {gap_norm[ID_BITS-2:0], {ID_BITS{1'b0}}};
        code_lj   = ~({CODE_BITS{1'b1}} >> top)
                  | (low_field >> (LEN_BITS'(top) + LEN_BITS'(1)));
        code_len  = LEN_BITS'({top, 1'b1});
    end

    // Append the code behind the occupied bits of the partial word
    always_comb begin
        used   = FILL_BITS'(WORD_BITS - 1) - fill_reg;
        stream = {partial_reg, {(STREAM_BITS - WORD_BITS){1'b0}}}
               | ({code_lj, {(STREAM_BITS - CODE_BITS){1'b0}}} >> used);
        total  = LEN_BITS'(used) + code_len;
        nfull     = '0;
        full_bits = '0;
        for (int k = 1; k <= MAX_WORDS; k++) begin
            if (!err && total >= LEN_BITS'(k * WORD_BITS)) begin
                nfull     = CNT_BITS'(k);
                full_bits = LEN_BITS'(k * WORD_BITS);
            end
        end
        rem_word = '0;
        for (int k = 0; k <= MAX_WORDS; k++) begin
            if (nfull == CNT_BITS'(k)) begin
                rem_word = stream[STREAM_BITS-1-k*WORD_BITS -: WORD_BITS];
            end
        end
        rem_bits = total - full_bits;
        new_fill = FILL_BITS'(WORD_BITS - 1) - FILL_BITS'(rem_bits);
    end

    // Assemble the full words and the flush or error transaction
    always_comb begin
        tail_en = in_item.end_of_list || err;
        tail    = '0;
        if (in_item.end_of_list) begin
            tail.is_last       = 1'b1;
            tail.order_error   = err;
            tail.packed_word   = err ? partial_reg : rem_word;
            tail.next_free_bit = err ? fill_reg : new_fill;
        end else begin
            tail.order_error   = 1'b1;
        end

        batch = '0;
        for (int k = 0; k < MAX_WORDS; k++) begin
            if (CNT_BITS'(k) < nfull) begin
                batch.res[k].packed_word = stream[STREAM_BITS-1-k*WORD_BITS -: WORD_BITS];
            end
        end
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (tail_en && nfull == CNT_BITS'(j)) begin
                batch.res[j] = tail;
            end
        end
        batch.count = in_valid ? (nfull + CNT_BITS'(tail_en)) : '0;
    end

    // Advance the coder state; end of list resets it, an order error holds it
    always_comb begin
        partial_next = partial_reg;
        fill_next    = fill_reg;
        prev_next    = prev_reg;
        if (in_valid) begin
            if (in_item.end_of_list) begin
                partial_next = '0;
                fill_next    = FILL_BITS'(WORD_BITS - 1);
                prev_next    = '0;
            end else if (!err) begin
                partial_next = rem_word;
                fill_next    = new_fill;
                prev_next    = in_item.doc_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            fill_reg    <= FILL_BITS'(WORD_BITS - 1);
            prev_reg    <= '0;
        end else begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            prev_reg    <= prev_next;
        end
    end

endmodule

// File: src/dgpe_res_fifo.sv
// ----------------------------------------------------------------------------
// dgpe_res_fifo
// Result queue: takes a batch of up to MAX_RESULTS transactions per cycle and
// hands them out one per cycle in order while rd_ready is high.
// ----------------------------------------------------------------------------
module dgpe_res_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dgpe_pkg::res_batch_t          wr_batch,
    output logic                          rd_valid,
    input  logic                          rd_ready,
    output dgpe_pkg::out_item_t           rd_item,
    output logic [dgpe_pkg::LVL_BITS-1:0] level
);
    import dgpe_pkg::*;

    out_item_t           mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_BITS-1:0] level_reg, level_next;
    logic                rd_fire;

    assign rd_valid = (level_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign rd_fire  = rd_valid && rd_ready;
    assign level    = level_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(wr_batch.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(rd_fire);
        level_next  = level_reg + LVL_BITS'(wr_batch.count) - LVL_BITS'(rd_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the batch in consecutive slots
    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (CNT_BITS'(j) < wr_batch.count) begin
                mem_reg[wr_ptr_reg + PTR_BITS'(j)] <= wr_batch.res[j];
            end
        end
    end

endmodule
